/* rtl/radio_frame_receiver_with_timeout_assert.svh */
// ----------------------------------------------------------------------------
// Radio frame receiver assertion macros
// Shared property shapes for the receiver's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RADIO_FRAME_RECEIVER_WITH_TIMEOUT_ASSERT_SVH
`define RADIO_FRAME_RECEIVER_WITH_TIMEOUT_ASSERT_SVH

// same-cycle implication
`define RFRT_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RFRT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rfrt_pkg.sv */
// ----------------------------------------------------------------------------
// Radio frame receiver package
// Shared constants, item types and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rfrt_pkg;

	localparam int RING_DEPTH   = 256;
	localparam int RING_AW      = $clog2(RING_DEPTH);
	localparam int MAX_PAYLOAD  = 32;
	localparam int LEN_W        = 6;
	localparam int POS_W        = 5;
	localparam int HEADER_BYTES = 9;
	localparam int FRAME_EXTRA  = 10;
	localparam int HCNT_W       = $clog2(HEADER_BYTES + 1);
	localparam int CMDQ_DEPTH   = 4;
	localparam int CMDQ_AW      = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW      = $clog2(CMDQ_DEPTH + 1);

	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] ASCII_ZERO = 8'd48;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_FIRST   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_SECOND  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_THIRD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT  = 3'd5;

	localparam logic [9:0]       RST_NODE_ADDRESS   = 10'd0;
	localparam logic [LEN_W-1:0] RST_PAYLOAD_LENGTH = 6'd8;
	localparam logic [7:0]       RST_PREFIX_FIRST   = 8'd82;
	localparam logic [7:0]       RST_PREFIX_SECOND  = 8'd66;
	localparam logic [7:0]       RST_PREFIX_THIRD   = 8'd78;
	localparam logic [7:0]       RST_TIMEOUT_LIMIT  = 8'd10;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic             result_kind;
		logic [7:0]       payload_byte;
		logic [POS_W-1:0] byte_position;
		logic             last_byte;
		logic             link_alive;
	} result_t;

	typedef struct packed {
		logic       is_tick;
		logic       frame_end;
		logic [7:0] rx_byte;
	} cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0]              payload_length;
		logic [7:0]                    timeout_limit;
		logic [HEADER_BYTES-1:0][7:0]  hdr;
	} bk_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_HDR  = 3'b010,
		ST_PAY  = 3'b100
	} bk_state_t;

endpackage

`default_nettype wire

/* rtl/rfrt_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/rfrt_front.sv */
// ----------------------------------------------------------------------------
// Receiver front end
// Accepts items, flags CR LF terminators and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrt_front
	import rfrt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t rx_item,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  wire logic  cmd_pop
);

	cmd_t               q_mem [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] cnt_q;
	logic [7:0]         prev_q;
	logic               push_ok;
	logic               pop_ok;
	cmd_t               new_cmd;

	assign full      = (cnt_q == CMDQ_CW'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rd_ptr_q];
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_pop && cmd_valid;

	always_comb begin
		new_cmd.is_tick   = (rx_item.kind == KIND_TICK);
		new_cmd.rx_byte   = rx_item.rx_byte;
		new_cmd.frame_end = (rx_item.rx_byte == CHAR_LF) && (prev_q == CHAR_CR);
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_mem[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			prev_q   <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_AW'(1);
				if (!new_cmd.is_tick) begin
					prev_q <= rx_item.rx_byte;
				end
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_AW'(1);
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + CMDQ_CW'(1);
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - CMDQ_CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/rfrt_back.sv */
// ----------------------------------------------------------------------------
// Receiver back end
// Ring store writes, header check, payload run and link timeout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radio_frame_receiver_with_timeout_assert.svh"

module rfrt_back
	import rfrt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire bk_cfg_t bcfg,
	input  wire logic    cmd_valid,
	input  wire cmd_t    cmd,
	output logic         cmd_pop,
	output logic         empty,
	input  wire logic    pop,
	output result_t      result
);

	bk_state_t          state_q;
	bk_state_t          state_d;
	logic [RING_AW-1:0] wr_idx_q;
	logic [RING_AW-1:0] start_q;
	logic [HCNT_W-1:0]  hcnt_q;
	logic [HCNT_W-1:0]  cmp_idx;
	logic [LEN_W-1:0]   pcnt_q;
	logic [7:0]         tick_cnt_q;
	logic               res_valid_q;
	result_t            res_q;
	logic               out_free;
	logic               load;
	result_t            load_res;
	logic               ram_we;
	logic [RING_AW-1:0] rd_addr;
	logic [7:0]         rdata;
	logic               len_ok;
	logic               lost;
	logic               hdr_bad;
	logic               pay_last;

	rfrt_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx_q),
		.wdata(cmd.rx_byte),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign out_free = !res_valid_q || pop;
	assign empty    = !res_valid_q;
	assign result   = res_q;
	assign len_ok   = (bcfg.payload_length != '0) &&
	                  ({1'b0, bcfg.payload_length} <= (LEN_W+1)'(MAX_PAYLOAD));
	assign lost     = (tick_cnt_q >= bcfg.timeout_limit);
	assign cmp_idx  = hcnt_q - HCNT_W'(1);
	assign hdr_bad  = (hcnt_q != '0) && (rdata != bcfg.hdr[cmp_idx]);
	assign pay_last = (LEN_W'(pcnt_q + LEN_W'(1)) == bcfg.payload_length);

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		ram_we   = 1'b0;
		load     = 1'b0;
		load_res = '0;
		rd_addr  = start_q + RING_AW'(HEADER_BYTES) + RING_AW'(pcnt_q);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.is_tick) begin
						if (out_free) begin
							cmd_pop              = 1'b1;
							load                 = 1'b1;
							load_res.result_kind = KIND_TICK;
							load_res.link_alive  = !lost;
						end
					end else begin
						cmd_pop = 1'b1;
						ram_we  = 1'b1;
						if (cmd.frame_end && len_ok) begin
							state_d = ST_HDR;
						end
					end
				end
			end
			ST_HDR: begin
				rd_addr = start_q + RING_AW'(hcnt_q);
				if (hdr_bad) begin
					state_d = ST_IDLE;
				end else if (hcnt_q == HCNT_W'(HEADER_BYTES)) begin
					state_d = ST_PAY;
				end
			end
			ST_PAY: begin
				if (out_free) begin
					load                   = 1'b1;
					load_res.result_kind   = KIND_BYTE;
					load_res.payload_byte  = rdata;
					load_res.byte_position = pcnt_q[POS_W-1:0];
					load_res.last_byte     = pay_last;
					rd_addr = start_q + RING_AW'(HEADER_BYTES) + RING_AW'(pcnt_q) + RING_AW'(1);
					if (pay_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
		if (state_q == ST_IDLE && cmd_pop && !cmd.is_tick) begin
			start_q <= wr_idx_q - (RING_AW'(bcfg.payload_length) + RING_AW'(FRAME_EXTRA));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_idx_q    <= '0;
			hcnt_q      <= '0;
			pcnt_q      <= '0;
			tick_cnt_q  <= RST_TIMEOUT_LIMIT;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			if (ram_we) begin
				wr_idx_q <= wr_idx_q + RING_AW'(1);
			end
			if (state_q == ST_IDLE) begin
				hcnt_q <= '0;
				pcnt_q <= '0;
				if (cmd_pop && cmd.is_tick) begin
					if (!lost) begin
						tick_cnt_q <= tick_cnt_q + 8'd1;
					end
				end
			end else if (state_q == ST_HDR) begin
				hcnt_q <= hcnt_q + HCNT_W'(1);
				if (state_d == ST_PAY) begin
					tick_cnt_q <= '0;
				end
			end else if (load) begin
				pcnt_q <= pcnt_q + LEN_W'(1);
			end
		end
	end

	`RFRT_ASSERT_IMPL(a_hcnt_range, state_q == ST_HDR, hcnt_q <= HCNT_W'(HEADER_BYTES), "header counter out of range")
	`RFRT_ASSERT_IMPL(a_pcnt_range, state_q == ST_PAY, pcnt_q < bcfg.payload_length, "payload counter past length")
	`RFRT_ASSERT_IMPL(a_pop_idle, cmd_pop, state_q == ST_IDLE, "command taken while busy")
	`RFRT_ASSERT_NEXT(a_frame_clear, (state_q == ST_HDR) && (state_d == ST_PAY), tick_cnt_q == '0, "tick counter not cleared on frame")

endmodule

`default_nettype wire

/* rtl/radio_frame_receiver_with_timeout.sv */
// ----------------------------------------------------------------------------
// Radio frame receiver with timeout
// Items are received bytes or timer ticks. A byte closing CR LF with a valid
// payload length starts a header check over the ring store; a matching frame
// yields payload items, the last one marked; each tick, one link status item.
// Input is a queue: push/full. Results are a queue: empty/pop, the oldest
// result shown while empty is low. Configuration writes use cfg_valid/ready
// with cfg_index selecting the register; cfg_ready is always high.
// Path: an item reaches the back end through a four-entry command queue; a
// tick result is registered as the back end takes the tick, and payload
// items follow a closing LF once the header check has passed.
// Throughput: while idle the back end takes a plain byte each cycle and a tick
// when the result register is free. A terminating byte holds off commands
// until the frame ends, giving one payload item per cycle while it is free.
// When the receiver holds pop low, the result register stays full, the back
// end waits at the next tick or payload item, the command queue fills and
// full is raised. Reset clears the queues and the write index, loads the
// register defaults and sets the tick counter to ten; the ring store content
// is left as is and must be written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_frame_receiver_with_timeout
	import rfrt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire item_t                 rx_item,
	output logic                       empty,
	input  wire logic                  pop,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [9:0]       node_address_q;
	logic [LEN_W-1:0] payload_length_q;
	logic [7:0]       prefix_first_q;
	logic [7:0]       prefix_second_q;
	logic [7:0]       prefix_third_q;
	logic [7:0]       timeout_limit_q;
	logic [23:0]      addr_dig_q;
	logic [23:0]      len_dig_q;
	bk_cfg_t          bcfg;
	logic             cmd_valid;
	cmd_t             cmd;
	logic             cmd_pop;

	function automatic logic [23:0] to_digits(input logic [9:0] v);
		logic [9:0] m;
		logic [6:0] r;
		logic [3:0] h;
		logic [3:0] t;
		logic [3:0] o;
		m = (v >= 10'd1000) ? (v - 10'd1000) : v;
		h = '0;
		for (int k = 1; k <= 9; k++) begin
			if (m >= 10'(k * 100)) begin
				h = 4'(k);
			end
		end
		r = 7'(m - ({6'b0, h} * 10'd100));
		t = '0;
		for (int k = 1; k <= 9; k++) begin
			if (r >= 7'(k * 10)) begin
				t = 4'(k);
			end
		end
		o = 4'(r - ({3'b0, t} * 7'd10));
		return {ASCII_ZERO + {4'b0, h}, ASCII_ZERO + {4'b0, t}, ASCII_ZERO + {4'b0, o}};
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q   <= RST_NODE_ADDRESS;
			payload_length_q <= RST_PAYLOAD_LENGTH;
			prefix_first_q   <= RST_PREFIX_FIRST;
			prefix_second_q  <= RST_PREFIX_SECOND;
			prefix_third_q   <= RST_PREFIX_THIRD;
			timeout_limit_q  <= RST_TIMEOUT_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NODE_ADDRESS:   node_address_q   <= cfg_data;
				CFG_PAYLOAD_LENGTH: payload_length_q <= cfg_data[LEN_W-1:0];
				CFG_PREFIX_FIRST:   prefix_first_q   <= cfg_data[7:0];
				CFG_PREFIX_SECOND:  prefix_second_q  <= cfg_data[7:0];
				CFG_PREFIX_THIRD:   prefix_third_q   <= cfg_data[7:0];
				CFG_TIMEOUT_LIMIT:  timeout_limit_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// digit bytes settle in the cycle after a register write
	always_ff @(posedge clk) begin
		addr_dig_q <= to_digits(node_address_q);
		len_dig_q  <= to_digits({{(10-LEN_W){1'b0}}, payload_length_q});
	end

	always_comb begin
		bcfg.payload_length = payload_length_q;
		bcfg.timeout_limit  = timeout_limit_q;
		bcfg.hdr[0]         = prefix_first_q;
		bcfg.hdr[1]         = prefix_second_q;
		bcfg.hdr[2]         = prefix_third_q;
		bcfg.hdr[3]         = addr_dig_q[23:16];
		bcfg.hdr[4]         = addr_dig_q[15:8];
		bcfg.hdr[5]         = addr_dig_q[7:0];
		bcfg.hdr[6]         = len_dig_q[23:16];
		bcfg.hdr[7]         = len_dig_q[15:8];
		bcfg.hdr[8]         = len_dig_q[7:0];
	end

	rfrt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.rx_item  (rx_item),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	rfrt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.bcfg     (bcfg),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire
